// File: rtl/core/text_console_glyph_renderer_macros.svh
// Assertion macros used by the text console glyph renderer engine.
// Define ASSERT_OFF to compile the checks out; relies on clk and rst in scope.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only outside reset.
`define TCGR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("tcgr check failed");
// Checked on every edge, reset included.
`define TCGR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("tcgr check failed");
`else
`define TCGR_ASSERT(lbl, prop)
`define TCGR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/core/tcgr_pkg.sv
// Shared types, constants and helpers for the text console glyph renderer.
// No dependencies.
package tcgr_pkg;

  localparam int GLYPH_HEIGHT = 16;
  localparam int FONT_ENTRIES = 256;
  localparam int FONT_SIZE    = FONT_ENTRIES * GLYPH_HEIGHT;
  localparam int FONT_AW      = $clog2(FONT_SIZE);
  localparam int LINE_W       = $clog2(GLYPH_HEIGHT);
  localparam int ROW_CNT_W    = $clog2(GLYPH_HEIGHT + 1);
  localparam int YPIX_W       = $clog2(256 * GLYPH_HEIGHT);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PIX  = 3'd4;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

  typedef enum logic [1:0] {
    ACT_PUT_CHAR   = 2'd0,
    ACT_SET_CURSOR = 2'd1,
    ACT_CLEAR      = 2'd2,
    ACT_LOAD_FONT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_GLYPH  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic        enabled;
    logic [7:0]  text_attr;
    logic [9:0]  columns;
    logic [8:0]  rows;
    logic [13:0] scan_line_pixels;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [FONT_AW-1:0] addr;
    logic [7:0]         data;
  } font_wr_t;

  typedef struct packed {
    logic               re;
    logic [FONT_AW-1:0] addr;
  } font_rd_t;

  // bit3 intensity picks 255 over 127, bits 2..0 enable R, G, B
  function automatic logic [31:0] nibble_color(input logic [3:0] nib);
    logic [7:0] level;
    level = nib[3] ? 8'd255 : 8'd127;
    return ALPHA_OPAQUE | {8'h00, (nib[2] ? level : 8'h00),
                           (nib[1] ? level : 8'h00), (nib[0] ? level : 8'h00)};
  endfunction

endpackage

// File: rtl/core/tcgr_font_ram.sv
// Generic single-write, single-read synchronous RAM; read data registered.
// Used as the glyph font store. No dependencies.
module tcgr_font_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/tcgr_cfg_regs.sv
// Configuration register file of the glyph renderer.
// Depends on tcgr_pkg for register indexes and the cfg_t bundle.
module tcgr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcgr_pkg::CFG_DW-1:0]      cfg_data,
  output tcgr_pkg::cfg_t                   cfg
);
  import tcgr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled          <= 1'b0;
      cfg.text_attr        <= 8'd7;
      cfg.columns          <= 10'd80;
      cfg.rows             <= 9'd25;
      cfg.scan_line_pixels <= 14'd640;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLED:   cfg.enabled          <= cfg_data[0];
        CFG_TEXT_ATTR: cfg.text_attr        <= cfg_data[7:0];
        CFG_COLUMNS:   cfg.columns          <= cfg_data[9:0];
        CFG_ROWS:      cfg.rows             <= cfg_data[8:0];
        CFG_SCAN_PIX:  cfg.scan_line_pixels <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/tcgr_engine.sv
// Cursor state, action decode, glyph row sequencer and output register.
// Depends on tcgr_pkg and the renderer assertion macros; drives the font RAM.
`include "text_console_glyph_renderer_macros.svh"
module tcgr_engine (
  input  logic               clk,
  input  logic               rst,
  input  tcgr_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [7:0]         char_code,
  input  logic [8:0]         cursor_col,
  input  logic [7:0]         cursor_row,
  input  logic [11:0]        font_index,
  input  logic [7:0]         font_byte,
  output tcgr_pkg::font_wr_t font_wr,
  output tcgr_pkg::font_rd_t font_rd,
  input  logic [7:0]         font_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [31:0]        byte_offset,
  output logic [7:0]         glyph_bits,
  output logic [31:0]        fg_color,
  output logic [31:0]        bg_color,
  output logic               last
);
  import tcgr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_GLYPH, S_EMIT} state_t;

  state_t                 state;
  logic [9:0]             cur_x;
  logic [7:0]             cur_y;
  logic [9:0]             draw_x;
  logic [7:0]             draw_y;
  logic [7:0]             draw_code;
  logic                   do_scroll;
  kind_t                  emit_kind;
  logic [FONT_AW-1:0]     font_base;
  logic                   blank;
  logic [31:0]            row_off;
  logic [ROW_CNT_W-1:0]   issue_cnt;
  logic [LINE_W-1:0]      line_cnt;
  logic                   pend;
  kind_t                  out_kind;

  logic                   acc;
  logic [9:0]             col_lim;
  logic [8:0]             row_lim;
  logic [10:0]            nx;
  logic [8:0]             ny;
  logic                   pc_draw;
  logic                   pc_check;
  logic                   pc_scroll;
  logic [9:0]             pc_dx;
  logic [7:0]             pc_code;
  logic [15:0]            pitch;
  logic [YPIX_W-1:0]      y_pix;
  logic [YPIX_W+15:0]     prep_prod;
  logic                   slot_free;
  logic                   move;
  logic                   issue;
  logic                   emit;
  logic                   glyph_last;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  assign col_lim = (cfg.columns == 10'd0) ? 10'd1 : cfg.columns;
  assign row_lim = (cfg.rows == 9'd0) ? 9'd1 :
                   ((cfg.rows > 9'd256) ? 9'd256 : cfg.rows);

  // put_char cursor update: control codes, wrap, scroll
  always_comb begin
    nx        = {1'b0, cur_x};
    ny        = {1'b0, cur_y};
    pc_draw   = 1'b0;
    pc_check  = 1'b1;
    pc_scroll = 1'b0;
    pc_dx     = cur_x;
    pc_code   = char_code;
    case (char_code)
      CH_CR: begin
        nx       = '0;
        pc_check = 1'b0;
      end
      CH_LF: begin
        nx = '0;
        ny = ny + 9'd1;
      end
      CH_TAB: nx = (nx + 11'd8) & ~11'd7;
      CH_BS: begin
        if (cur_x != 10'd0) begin
          nx      = nx - 11'd1;
          pc_draw = 1'b1;
          pc_dx   = cur_x - 10'd1;
          pc_code = CH_SPACE;
        end
      end
      default: begin
        pc_draw = 1'b1;
        nx      = nx + 11'd1;
      end
    endcase
    if (pc_check) begin
      if (nx >= {1'b0, col_lim}) begin
        nx = '0;
        ny = ny + 9'd1;
      end
      if (ny >= row_lim) begin
        pc_scroll = 1'b1;
        ny        = row_lim - 9'd1;
      end
    end
  end

  assign font_wr.we   = acc && cfg.enabled && (action == ACT_LOAD_FONT) &&
                        (int'(font_index) < FONT_SIZE);
  assign font_wr.addr = font_index[FONT_AW-1:0];
  assign font_wr.data = font_byte;

  assign pitch     = {cfg.scan_line_pixels, 2'b00};
  assign y_pix     = YPIX_W'(int'(draw_y) * GLYPH_HEIGHT);
  assign prep_prod = y_pix * pitch;

  assign slot_free  = !out_valid || out_ready;
  assign move       = (state == S_GLYPH) && pend && slot_free;
  assign issue      = (state == S_GLYPH) && (issue_cnt < ROW_CNT_W'(GLYPH_HEIGHT)) &&
                      (!pend || move);
  assign emit       = (state == S_EMIT) && slot_free;
  assign glyph_last = (line_cnt == LINE_W'(GLYPH_HEIGHT - 1));

  assign font_rd.re   = issue;
  assign font_rd.addr = font_base + FONT_AW'(issue_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_x     <= '0;
      cur_y     <= '0;
      pend      <= 1'b0;
      issue_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new beat loads in the same cycle the old one leaves
      if (out_valid && out_ready && !move && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc && cfg.enabled) begin
            case (action)
              ACT_SET_CURSOR: begin
                if ({1'b0, cursor_col} < col_lim) begin
                  cur_x <= {1'b0, cursor_col};
                end
                if ({1'b0, cursor_row} < row_lim) begin
                  cur_y <= cursor_row;
                end
              end
              ACT_CLEAR: begin
                cur_x     <= '0;
                cur_y     <= '0;
                emit_kind <= KIND_CLEAR;
                state     <= S_EMIT;
              end
              ACT_PUT_CHAR: begin
                cur_x     <= nx[9:0];
                cur_y     <= ny[7:0];
                draw_x    <= pc_dx;
                draw_y    <= cur_y;
                draw_code <= pc_code;
                do_scroll <= pc_scroll;
                emit_kind <= KIND_SCROLL;
                if (pc_draw) begin
                  state <= S_PREP;
                end else if (pc_scroll) begin
                  state <= S_EMIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_PREP: begin
          row_off   <= 32'(prep_prod) + 32'({draw_x, 5'b00000});
          font_base <= FONT_AW'(int'(draw_code) * GLYPH_HEIGHT);
          blank     <= (int'(draw_code) >= FONT_ENTRIES);
          issue_cnt <= '0;
          line_cnt  <= '0;
          pend      <= 1'b0;
          state     <= S_GLYPH;
        end
        S_GLYPH: begin
          if (issue) begin
            issue_cnt <= issue_cnt + ROW_CNT_W'(1);
          end
          pend <= issue || (pend && !move);
          if (move) begin
            out_valid   <= 1'b1;
            out_kind    <= KIND_GLYPH;
            byte_offset <= row_off;
            glyph_bits  <= blank ? 8'h00 : font_rdata;
            fg_color    <= nibble_color(cfg.text_attr[3:0]);
            bg_color    <= nibble_color(cfg.text_attr[7:4]);
            last        <= glyph_last && !do_scroll;
            row_off     <= row_off + 32'(pitch);
            line_cnt    <= line_cnt + LINE_W'(1);
            if (glyph_last) begin
              state <= do_scroll ? S_EMIT : S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_valid   <= 1'b1;
            out_kind    <= emit_kind;
            byte_offset <= '0;
            glyph_bits  <= '0;
            fg_color    <= '0;
            bg_color    <= (emit_kind == KIND_CLEAR) ? nibble_color(cfg.text_attr[7:4])
                                                     : ALPHA_OPAQUE;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign kind = out_kind;

  `TCGR_ASSERT(a_pend_in_glyph, pend |-> state == S_GLYPH)
  `TCGR_ASSERT(a_issue_bound, issue_cnt <= ROW_CNT_W'(GLYPH_HEIGHT))
  `TCGR_ASSERT(a_read_lands, issue |=> pend)
  `TCGR_ASSERT(a_final_row_idle, (move && glyph_last && !do_scroll) |=> (state == S_IDLE && out_valid && last))
  `TCGR_ASSERT_ALWAYS(a_reset_quiet, rst |=> (!out_valid && state == S_IDLE && !pend))

endmodule

// File: rtl/core/text_console_glyph_renderer.sv
// Text console glyph renderer: cursor, control codes and 8-pixel font rows.
// put_char: accept, the offset multiply in S_PREP, a font read, then one row
// beat per cycle while the output is not stalled; a scroll adds a beat after
// the rows. Set_cursor and load_font leave the block idle; clear and a bare
// scroll emit one beat from S_EMIT. Sync reset homes the cursor and reloads the
// registers; the font store is not cleared and must be loaded before use.
module text_console_glyph_renderer (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  char_code,
  input  logic [8:0]  cursor_col,
  input  logic [7:0]  cursor_row,
  input  logic [11:0] font_index,
  input  logic [7:0]  font_byte,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] byte_offset,
  output logic [7:0]  glyph_bits,
  output logic [31:0] fg_color,
  output logic [31:0] bg_color,
  output logic        last
);
  import tcgr_pkg::*;

  cfg_t     cfg;
  font_wr_t font_wr;
  font_rd_t font_rd;
  logic [7:0] font_rdata;

  // Register file, always ready; the host must write it only while no item is in flight, unchecked here.
  tcgr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Font store: one byte per glyph row, written by load_font beats,
  // read one row per cycle while a glyph is drawn and the output is not stalled.
  tcgr_font_ram #(
    .DEPTH (FONT_SIZE),
    .WIDTH (8)
  ) u_font (
    .clk   (clk),
    .we    (font_wr.we),
    .waddr (font_wr.addr),
    .wdata (font_wr.data),
    .re    (font_rd.re),
    .raddr (font_rd.addr),
    .rdata (font_rdata)
  );

  // Decode, cursor update, row sequencing and the output register.
  tcgr_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .char_code   (char_code),
    .cursor_col  (cursor_col),
    .cursor_row  (cursor_row),
    .font_index  (font_index),
    .font_byte   (font_byte),
    .font_wr     (font_wr),
    .font_rd     (font_rd),
    .font_rdata  (font_rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .byte_offset (byte_offset),
    .glyph_bits  (glyph_bits),
    .fg_color    (fg_color),
    .bg_color    (bg_color),
    .last        (last)
  );

endmodule

// File: tb/text_console_glyph_renderer_tb.sv
// Self-checking bench for text_console_glyph_renderer: command beats in, framebuffer
// operation beats out, checked against an in-bench console predictor.
// Depends on tcgr_pkg and the renderer RTL only.
`timescale 1ns / 100ps

module text_console_glyph_renderer_tb;
  import tcgr_pkg::*;

  // one console command as it sits on the input port
  typedef struct {
    action_t     act;
    logic [7:0]  code;
    logic [8:0]  col;
    logic [7:0]  row;
    logic [11:0] fidx;
    logic [7:0]  fbyte;
  } console_cmd_t;

  // one framebuffer operation as it leaves the output port
  typedef struct {
    kind_t       op_kind;
    logic [31:0] offset;
    logic [7:0]  bits;
    logic [31:0] fg;
    logic [31:0] bg;
    logic        last;
  } fb_op_t;

  localparam int DRAIN_CYCLES = 40;   // idle wait after the queues empty, for a command with no result

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [7:0]  char_code = '0;
  logic [8:0]  cursor_col = '0;
  logic [7:0]  cursor_row = '0;
  logic [11:0] font_index = '0;
  logic [7:0]  font_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [31:0] byte_offset;
  logic [7:0]  glyph_bits;
  logic [31:0] fg_color;
  logic [31:0] bg_color;
  logic        last;

  // commands waiting for the driver, and framebuffer ops waiting for the monitor
  console_cmd_t console_cmds[$];
  console_cmd_t cmd_on_bus;
  fb_op_t       fb_ops_q[$];
  fb_op_t       want_op;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;

  // console state as the predictor sees it
  logic        en_r   = 1'b0;
  logic [7:0]  attr_r = 8'd7;
  logic [9:0]  cols_r = 10'd80;
  logic [8:0]  rows_r = 9'd25;
  logic [13:0] scan_r = 14'd640;
  int unsigned cur_x  = 0;
  int unsigned cur_y  = 0;
  logic [7:0]  font_mem [FONT_SIZE];

  // scratch for the ops one command produces (16 rows plus a scroll at most)
  fb_op_t      step_ops [GLYPH_HEIGHT+1];
  int          step_n;

  // stimulus side: which glyphs are fully loaded, so no unwritten font row is read
  bit          code_ready [256];
  logic [7:0]  ready_codes[$];

  text_console_glyph_renderer i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .char_code   (char_code),
    .cursor_col  (cursor_col),
    .cursor_row  (cursor_row),
    .font_index  (font_index),
    .font_byte   (font_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .byte_offset (byte_offset),
    .glyph_bits  (glyph_bits),
    .fg_color    (fg_color),
    .bg_color    (bg_color),
    .last        (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // attribute nibble to opaque ARGB: intensity picks full or half level per channel
  function automatic logic [31:0] nib_argb(input logic [3:0] n);
    logic [7:0] lvl;
    lvl = n[3] ? 8'hFF : 8'h7F;
    return {8'hFF, lvl & {8{n[2]}}, lvl & {8{n[1]}}, lvl & {8{n[0]}}};
  endfunction

  // zero columns behaves as one
  function automatic int unsigned col_limit();
    return (cols_r == 0) ? 1 : cols_r;
  endfunction

  // zero rows behaves as one, anything past 256 is clamped
  function automatic int unsigned row_limit();
    if (rows_r == 0) return 1;
    return (rows_r > 256) ? 256 : rows_r;
  endfunction

  function automatic fb_op_t mk_op(input kind_t k, input logic [31:0] off,
                                   input logic [7:0] bits, input logic [31:0] fg,
                                   input logic [31:0] bg);
    fb_op_t o;
    o.op_kind = k;
    o.offset  = off;
    o.bits    = bits;
    o.fg      = fg;
    o.bg      = bg;
    o.last    = 1'b0;
    return o;
  endfunction

  // one op per glyph row at the current cell; offset wraps at 32 bits
  function automatic void draw_cell(input logic [7:0] code);
    logic [63:0] pitch;
    logic [63:0] base;
    logic [63:0] off;
    int          line;
    pitch = 64'(scan_r) * 4;
    base  = 64'(cur_y) * GLYPH_HEIGHT * pitch + 64'(cur_x) * 32;
    for (line = 0; line < GLYPH_HEIGHT; line++) begin
      off = base + 64'(line) * pitch;
      step_ops[step_n] = mk_op(KIND_GLYPH, off[31:0], font_mem[code * GLYPH_HEIGHT + line],
                               nib_argb(attr_r[3:0]), nib_argb(attr_r[7:4]));
      step_n++;
    end
  endfunction

  // advance the console by one accepted command and queue the ops it must produce
  function automatic void render_cmd(input console_cmd_t c);
    int unsigned cl;
    int unsigned rl;
    int          i;
    cl     = col_limit();
    rl     = row_limit();
    step_n = 0;
    if (!en_r) return;
    case (c.act)
      ACT_LOAD_FONT: begin
        if (c.fidx < FONT_SIZE) font_mem[c.fidx] = c.fbyte;
      end
      ACT_SET_CURSOR: begin
        // each axis moves only if in range
        if (c.col < cl) cur_x = 32'(c.col);
        if (c.row < rl) cur_y = 32'(c.row);
      end
      ACT_CLEAR: begin
        cur_x = 0;
        cur_y = 0;
        step_ops[0] = mk_op(KIND_CLEAR, '0, '0, '0, nib_argb(attr_r[7:4]));
        step_n = 1;
      end
      default: begin
        if (c.code == CH_CR) begin
          cur_x = 0;  // no wrap or scroll check
        end else begin
          if (c.code == CH_LF) begin
            cur_x = 0;
            cur_y++;
          end else if (c.code == CH_TAB) begin
            cur_x = (cur_x + 8) & ~32'd7;
          end else if (c.code == CH_BS) begin
            // backspace erases with a blank cell, but only if not at column zero
            if (cur_x > 0) begin
              cur_x--;
              draw_cell(CH_SPACE);
            end
          end else begin
            // a cursor left past shrunk limits still draws where it stands
            draw_cell(c.code);
            cur_x++;
          end
          if (cur_x >= cl) begin
            cur_x = 0;
            cur_y++;
          end
          if (cur_y >= rl) begin
            step_ops[step_n] = mk_op(KIND_SCROLL, '0, '0, '0, ALPHA_OPAQUE);
            step_n++;
            cur_y = rl - 1;
          end
          cur_x &= 32'h3FF;
          cur_y &= 32'hFF;
        end
      end
    endcase
    if (step_n > 0) step_ops[step_n-1].last = 1'b1;
    for (i = 0; i < step_n; i++) fb_ops_q.push_back(step_ops[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Command builders (unused fields carry random noise)
  // ---------------------------------------------------------------------------

  function automatic console_cmd_t noise_cmd();
    console_cmd_t c;
    c.act   = action_t'($urandom_range(3));
    c.code  = 8'($urandom);
    c.col   = 9'($urandom);
    c.row   = 8'($urandom);
    c.fidx  = 12'($urandom);
    c.fbyte = 8'($urandom);
    return c;
  endfunction

  function automatic void queue_put(input logic [7:0] code);
    console_cmd_t c;
    c      = noise_cmd();
    c.act  = ACT_PUT_CHAR;
    c.code = code;
    console_cmds.push_back(c);
  endfunction

  function automatic void queue_cursor(input logic [8:0] col, input logic [7:0] row);
    console_cmd_t c;
    c     = noise_cmd();
    c.act = ACT_SET_CURSOR;
    c.col = col;
    c.row = row;
    console_cmds.push_back(c);
  endfunction

  function automatic void queue_clear();
    console_cmd_t c;
    c     = noise_cmd();
    c.act = ACT_CLEAR;
    console_cmds.push_back(c);
  endfunction

  function automatic void queue_font(input logic [11:0] idx, input logic [7:0] val);
    console_cmd_t c;
    c       = noise_cmd();
    c.act   = ACT_LOAD_FONT;
    c.fidx  = idx;
    c.fbyte = val;
    console_cmds.push_back(c);
  endfunction

  // all rows of one glyph; first row solid and second empty for the byte extremes
  function automatic void queue_glyph(input logic [7:0] code);
    int line;
    for (line = 0; line < GLYPH_HEIGHT; line++)
      queue_font(12'(code * GLYPH_HEIGHT + line),
                 (line == 0) ? 8'hFF : (line == 1) ? 8'h00 : 8'($urandom));
    if (en_r && !code_ready[code]) begin
      code_ready[code] = 1'b1;
      ready_codes.push_back(code);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops the next command once the bus slot frees up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) render_cmd(cmd_on_bus);
      if (!in_valid || in_ready) begin
        if (console_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus = console_cmds.pop_front();
          action     <= cmd_on_bus.act;
          char_code  <= cmd_on_bus.code;
          cursor_col <= cmd_on_bus.col;
          cursor_row <= cmd_on_bus.row;
          font_index <= cmd_on_bus.fidx;
          font_byte  <= cmd_on_bus.fbyte;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat against the oldest predicted op
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fb_ops_q.size() == 0) begin
          flag_mismatch("unexpected beat, kind", '0, 32'(kind));
        end else begin
          want_op = fb_ops_q.pop_front();
          if (kind !== want_op.op_kind)
            flag_mismatch("kind", 32'(want_op.op_kind), 32'(kind));
          if (byte_offset !== want_op.offset)
            flag_mismatch("byte_offset", want_op.offset, byte_offset);
          if (glyph_bits !== want_op.bits)
            flag_mismatch("glyph_bits", 32'(want_op.bits), 32'(glyph_bits));
          if (fg_color !== want_op.fg) flag_mismatch("fg_color", want_op.fg, fg_color);
          if (bg_color !== want_op.bg) flag_mismatch("bg_color", want_op.bg, bg_color);
          if (last !== want_op.last) flag_mismatch("last", 32'(want_op.last), 32'(last));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------

  // register write; bits above the register width carry noise the block must drop
  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    logic [13:0] d;
    d = 14'($urandom);
    case (idx)
      CFG_ENABLED:   d[0]   = val[0];
      CFG_TEXT_ATTR: d[7:0] = val[7:0];
      CFG_COLUMNS:   d[9:0] = val[9:0];
      CFG_ROWS:      d[8:0] = val[8:0];
      default:       d      = val;
    endcase
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLED:   en_r   = d[0];
      CFG_TEXT_ATTR: attr_r = d[7:0];
      CFG_COLUMNS:   cols_r = d[9:0];
      CFG_ROWS:      rows_r = d[8:0];
      CFG_SCAN_PIX:  scan_r = d;
      default: ;
    endcase
  endtask

  task automatic set_console(input logic [7:0] attr, input logic [9:0] cols,
                             input logic [8:0] rows, input logic [13:0] scan);
    write_reg(CFG_TEXT_ATTR, 14'(attr));
    write_reg(CFG_COLUMNS, 14'(cols));
    write_reg(CFG_ROWS, 14'(rows));
    write_reg(CFG_SCAN_PIX, scan);
  endtask

  // all commands taken, all ops seen, then room for a command with no result
  task automatic wait_drained();
    while (console_cmds.size() != 0 || in_valid || fb_ops_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly printable text from loaded glyphs, with control codes, cursor moves,
  // clears and font updates mixed in
  task automatic run_random(input int unsigned count);
    int unsigned made;
    int unsigned r;
    int unsigned c_top;
    int unsigned r_top;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 55) begin
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0:       queue_put(CH_BS);
            1:       queue_put(CH_TAB);
            2:       queue_put(CH_LF);
            default: queue_put(CH_CR);
          endcase
        end else begin
          queue_put(ready_codes[$urandom_range(ready_codes.size() - 1)]);
        end
        made++;
      end else if (r < 75) begin
        // half anywhere, half hugging the right and bottom edges
        if ($urandom_range(1)) begin
          queue_cursor(9'($urandom), 8'($urandom));
        end else begin
          c_top = ((col_limit() > 512) ? 512 : col_limit()) - 1;
          r_top = row_limit() - 1;
          queue_cursor(9'($urandom_range(c_top, (c_top > 2) ? c_top - 2 : 0)),
                       8'($urandom_range(r_top, (r_top > 2) ? r_top - 2 : 0)));
        end
        made++;
      end else if (r < 80) begin
        queue_clear();
        made++;
      end else if (r < 95) begin
        queue_font(12'($urandom), 8'($urandom));
        made++;
      end else begin
        queue_glyph(8'($urandom));
        made += GLYPH_HEIGHT;
      end
    end
    wait_drained();
  endtask

  initial begin
    int i;
    send_idle_pct  = 18;
    recv_stall_pct = 71;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // out of reset the console is disabled: everything is dropped silently
    queue_put(8'h41);
    queue_clear();
    queue_font(12'h410, 8'hA5);
    queue_cursor(9'd3, 8'd3);
    wait_drained();

    write_reg(CFG_ENABLED, 14'd1);

    // font: all-zero and all-one codes, both halves, the blank used by backspace
    queue_glyph(8'h00);
    queue_glyph(CH_SPACE);
    queue_glyph(8'h41);
    queue_glyph(8'h7F);
    queue_glyph(8'h80);
    queue_glyph(8'hFF);
    wait_drained();

    // control codes and edge cases on the reset geometry (80 x 25, pitch 2560)
    queue_put(8'h41);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put(8'h80);
    queue_put(CH_CR);
    queue_put(CH_BS);                 // at column zero: nothing drawn
    queue_put(CH_TAB);
    queue_put(CH_BS);                 // erases the cell left of the tab stop
    queue_put(CH_LF);
    queue_cursor(9'd79, 8'd24);
    queue_put(8'h7F);                 // last cell: wrap plus scroll
    queue_cursor(9'd80, 8'd25);       // both axes out of range, cursor kept
    queue_put(CH_LF);                 // on the bottom row: scroll alone
    queue_cursor(9'd78, 8'd3);
    queue_put(CH_TAB);                // tab stop lands on the column limit
    queue_cursor(9'd511, 8'd255);
    queue_clear();
    wait_drained();

    // largest geometry, farthest cell
    set_console(8'h0F, 10'd1023, 9'd511, 14'd16383);
    queue_cursor(9'd511, 8'd255);
    queue_put(8'hFF);
    wait_drained();

    // zero limits act as one; the cursor now sits far outside them
    set_console(8'hF8, 10'd0, 9'd0, 14'd0);
    queue_put(CH_SPACE);
    queue_put(8'h41);
    queue_put(CH_BS);
    queue_put(CH_LF);
    queue_clear();
    wait_drained();

    // sender idles a little, receiver stalls a lot
    set_console(8'($urandom), 10'd80, 9'd25, 14'd640);
    run_random(65);
    set_console(8'($urandom), 10'd1, 9'd1, 14'd1);
    run_random(65);

    // the other way round
    send_idle_pct  = 71;
    recv_stall_pct = 18;
    set_console(8'($urandom), 10'd512, 9'd256, 14'd8192);
    run_random(65);
    set_console(8'($urandom), 10'd7, 9'd3, 14'd100);   // shrinks under the cursor
    run_random(65);

    // full throughput both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_console(8'($urandom), 10'd1023, 9'd511, 14'd16383);
    run_random(65);
    for (i = 0; i < 2; i++) begin
      set_console(8'($urandom), 10'($urandom_range(1023)), 9'($urandom_range(511)),
                  14'($urandom));
      run_random(35);
    end

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
